// File: sv/tsd_pkg.sv
// Shared codes, types and constants for the telnet stream deframer.
package tsd_pkg;

  localparam logic [7:0] CODE_IAC  = 8'd255;
  localparam logic [7:0] CODE_SB   = 8'd250;
  localparam logic [7:0] CODE_SE   = 8'd240;
  localparam logic [7:0] CODE_WILL = 8'd251;
  localparam logic [7:0] CODE_WONT = 8'd252;
  localparam logic [7:0] CODE_DO   = 8'd253;
  localparam logic [7:0] CODE_DONT = 8'd254;

  localparam int QUEUE_DEPTH = 4;
  localparam int TDATA_W     = 24;

  typedef enum logic [2:0] {
    EV_DATA   = 3'd0,
    EV_NEGO   = 3'd1,
    EV_CMD    = 3'd2,
    EV_SBDATA = 3'd3,
    EV_SBEND  = 3'd4
  } event_kind_t;

  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  data;
    logic [7:0]  option;
    logic [1:0]  verb;
  } event_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// File: sv/tsd_front.sv
// Front end: accepts bytes, tracks the telnet parse phase and classifies events.
module tsd_front
  import tsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  queue_stat_t q_stat,
  output logic        push,
  output event_t      push_ent
);

  typedef enum logic [5:0] {
    PH_NORMAL = 6'b000001,
    PH_IAC    = 6'b000010,
    PH_VERB   = 6'b000100,
    PH_SBOPT  = 6'b001000,
    PH_SBBODY = 6'b010000,
    PH_SBIAC  = 6'b100000
  } phase_t;

  phase_t     phase, phase_next;
  logic [1:0] held_verb, held_verb_next;
  logic [7:0] held_option, held_option_next;
  logic [7:0] verb_diff;
  logic       emit;
  logic       accept;

  assign s_axis_tready = !q_stat.full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign verb_diff     = s_axis_tdata - CODE_WILL;

  always_comb begin
    phase_next       = phase;
    held_verb_next   = held_verb;
    held_option_next = held_option;
    emit             = 1'b0;
    push_ent.kind    = EV_DATA;
    push_ent.data    = s_axis_tdata;
    push_ent.option  = held_option;
    push_ent.verb    = held_verb;
    case (phase)
      PH_IAC: begin
        if (s_axis_tdata inside {[CODE_WILL:CODE_DONT]}) begin
          held_verb_next = verb_diff[1:0];
          phase_next     = PH_VERB;
        end else if (s_axis_tdata == CODE_SB) begin
          phase_next = PH_SBOPT;
        end else begin
          emit          = 1'b1;
          push_ent.kind = EV_CMD;
          phase_next    = PH_NORMAL;
        end
      end
      PH_VERB: begin
        emit            = 1'b1;
        push_ent.kind   = EV_NEGO;
        push_ent.option = s_axis_tdata;
        phase_next      = PH_NORMAL;
      end
      PH_SBOPT: begin
        held_option_next = s_axis_tdata;
        phase_next       = PH_SBBODY;
      end
      PH_SBBODY: begin
        if (s_axis_tdata == CODE_IAC) begin
          phase_next = PH_SBIAC;
        end else begin
          emit          = 1'b1;
          push_ent.kind = EV_SBDATA;
        end
      end
      PH_SBIAC: begin
        emit = 1'b1;
        if (s_axis_tdata == CODE_SE) begin
          push_ent.kind = EV_SBEND;
          phase_next    = PH_NORMAL;
        end else begin
          // any other escaped byte goes on as body data
          push_ent.kind = EV_SBDATA;
          phase_next    = PH_SBBODY;
        end
      end
      default: begin
        if (s_axis_tdata == CODE_IAC) begin
          phase_next = PH_IAC;
        end else begin
          emit          = 1'b1;
          push_ent.kind = EV_DATA;
          phase_next    = PH_NORMAL;
        end
      end
    endcase
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_NORMAL;
      held_verb   <= 2'd0;
      held_option <= 8'd0;
    end else if (accept) begin
      phase       <= phase_next;
      held_verb   <= held_verb_next;
      held_option <= held_option_next;
    end
  end

endmodule

// File: sv/tsd_queue.sv
// Short event queue between the classifying front end and the output back end.
module tsd_queue
  import tsd_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  event_t      push_ent,
  input  logic        pop,
  output event_t      head,
  output queue_stat_t stat
);

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  event_t          slots [Depth];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign stat.full  = (count == CW'(Depth));
  assign stat.empty = (count == '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/tsd_back.sv
// Back end: formats queued events and holds them in the output register.
module tsd_back
  import tsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  event_t             head,
  input  queue_stat_t        q_stat,
  output logic               pop,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic [2:0]         m_axis_tuser
);

  event_t     fmt;
  event_t     out_ent;
  logic       out_valid;

  // fields that carry nothing for a kind go out as zero
  always_comb begin
    fmt = head;
    case (head.kind)
      EV_DATA: begin
        fmt.option = 8'd0;
        fmt.verb   = 2'd0;
      end
      EV_NEGO: begin
        fmt.data = 8'd0;
      end
      EV_CMD: begin
        fmt.option = 8'd0;
        fmt.verb   = 2'd0;
      end
      EV_SBDATA: begin
        fmt.verb = 2'd0;
      end
      EV_SBEND: begin
        fmt.data = 8'd0;
        fmt.verb = 2'd0;
      end
      default: begin
        fmt.data   = 8'd0;
        fmt.option = 8'd0;
        fmt.verb   = 2'd0;
      end
    endcase
  end

  assign pop = !q_stat.empty && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_ent <= fmt;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_ent.kind;
  assign m_axis_tdata  = {{(TDATA_W - 18){1'b0}}, out_ent.verb, out_ent.option, out_ent.data};

endmodule

// File: sv/telnet_stream_deframer_unit.sv
// Telnet stream deframer top level: byte stream in, telnet events out.
//
// Input channel s_axis: one received telnet byte per item in tdata[7:0].
// Output channel m_axis: one event per item; tuser carries the event kind
// (0 data, 1 negotiation, 2 command, 3 subnegotiation data, 4 subnegotiation
// end) and tdata carries byte [7:0], option [15:8] and verb [17:16].
// Bytes that only open a sequence (IAC, IAC verb, IAC SB, the SB option)
// give no output item; the event comes with the byte that completes it.
// Throughput: one byte per cycle, sustained, as long as m_axis drains.
// An event is written into the queue at the edge that accepts its completing byte
// and then loaded into the output register that presents it on m_axis.
// A QueueDepth-entry queue sits between the parser and the output register;
// while m_axis stalls the parser keeps taking bytes until the queue fills,
// then s_axis_tready drops. Output payload holds steady while stalled.
// Reset (rst, synchronous) returns the parser to the normal data phase,
// clears the held verb and option and empties the queue and output.
module telnet_stream_deframer_unit
  import tsd_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // in_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // event_byte, event_option, event_verb, zero pad
  output logic [2:0]         m_axis_tuser    // event_kind
);

  queue_stat_t q_stat;
  logic        push;
  logic        pop;
  event_t      push_ent;
  event_t      head;

  tsd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_stat        (q_stat),
    .push          (push),
    .push_ent      (push_ent)
  );

  tsd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  tsd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_stat        (q_stat),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_push_kind_known: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_ent.kind <= EV_SBEND))
    else $error("front end pushed an undefined event kind");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !push)
    else $error("event pushed into a full queue");

  // queue entry at the push edge, output register load at the next edge
  a_fast_path: assert property (@(posedge clk) disable iff (rst)
    (push && q_stat.empty && (!m_axis_tvalid || m_axis_tready)) |=> ##1 m_axis_tvalid)
    else $error("event did not reach the output register in one cycle");

  a_out_kind_known: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser <= EV_SBEND))
    else $error("output carries an undefined event kind");

endmodule

// File: tb/tsd_checker.sv
// Scoreboard for the telnet deframer: predicts events from accepted bytes and checks m_axis.
`timescale 1ns / 1ps

module tsd_checker
  import tsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [7:0]         s_tdata,    // in_byte
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [TDATA_W-1:0] m_tdata,    // event_byte, event_option, event_verb, zero pad
  input  logic [2:0]         m_tuser,    // event_kind
  output int                 fail_count,
  output int                 pending
);

  typedef enum logic [2:0] {
    PH_NORMAL     = 3'd0,
    PH_AFTER_IAC  = 3'd1,
    PH_AFTER_VERB = 3'd2,
    PH_SB_OPTION  = 3'd3,
    PH_SB_BODY    = 3'd4,
    PH_SB_IAC     = 3'd5
  } parse_phase_t;

  event_t       expected_events[$];
  parse_phase_t phase;
  logic [1:0]   held_verb;
  logic [7:0]   held_option;

  always @(posedge clk) begin
    event_t     exp_ev;
    event_t     got_ev;
    logic       produced;
    logic [7:0] b;
    if (rst) begin
      phase       = PH_NORMAL;
      held_verb   = 2'd0;
      held_option = 8'd0;
      expected_events.delete();
    end else begin
      // predict the event, if any, caused by an accepted byte
      if (s_tvalid && s_tready) begin
        b        = s_tdata;
        produced = 1'b0;
        exp_ev   = '0;
        case (phase)
          PH_AFTER_IAC: begin
            if (b >= CODE_WILL && b <= CODE_DONT) begin
              held_verb = 2'(b - CODE_WILL);
              phase     = PH_AFTER_VERB;
            end else if (b == CODE_SB) begin
              phase = PH_SB_OPTION;
            end else begin
              phase       = PH_NORMAL;
              exp_ev.kind = EV_CMD;
              exp_ev.data = b;
              produced    = 1'b1;
            end
          end
          PH_AFTER_VERB: begin
            phase         = PH_NORMAL;
            exp_ev.kind   = EV_NEGO;
            exp_ev.option = b;
            exp_ev.verb   = held_verb;
            produced      = 1'b1;
          end
          PH_SB_OPTION: begin
            held_option = b;
            phase       = PH_SB_BODY;
          end
          PH_SB_BODY: begin
            if (b == CODE_IAC) begin
              phase = PH_SB_IAC;
            end else begin
              exp_ev.kind   = EV_SBDATA;
              exp_ev.data   = b;
              exp_ev.option = held_option;
              produced      = 1'b1;
            end
          end
          PH_SB_IAC: begin
            exp_ev.option = held_option;
            produced      = 1'b1;
            if (b == CODE_SE) begin
              phase       = PH_NORMAL;
              exp_ev.kind = EV_SBEND;
            end else begin
              // any other byte after IAC in the body is passed on as body data
              phase       = PH_SB_BODY;
              exp_ev.kind = EV_SBDATA;
              exp_ev.data = b;
            end
          end
          default: begin
            phase = PH_NORMAL;
            if (b == CODE_IAC) begin
              phase = PH_AFTER_IAC;
            end else begin
              exp_ev.kind = EV_DATA;
              exp_ev.data = b;
              produced    = 1'b1;
            end
          end
        endcase
        if (produced) expected_events.insert(expected_events.size(), exp_ev);
      end

      if (m_tvalid && m_tready) begin
        got_ev.kind   = event_kind_t'(m_tuser);
        got_ev.data   = m_tdata[7:0];
        got_ev.option = m_tdata[15:8];
        got_ev.verb   = m_tdata[17:16];
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event kind=%0d byte=%h option=%h verb=%0d",
                   $time, m_tuser, got_ev.data, got_ev.option, got_ev.verb);
          fail_count++;
        end else begin
          exp_ev = expected_events.pop_front();
          if (got_ev.kind != exp_ev.kind || got_ev.data != exp_ev.data ||
              got_ev.option != exp_ev.option || got_ev.verb != exp_ev.verb ||
              m_tdata[TDATA_W-1:18] != '0) begin
            $display("%0t: event mismatch: expected kind=%0d byte=%h option=%h verb=%0d",
                     $time, exp_ev.kind, exp_ev.data, exp_ev.option, exp_ev.verb);
            $display("%0t:                 actual kind=%0d byte=%h option=%h verb=%0d pad=%h",
                     $time, m_tuser, got_ev.data, got_ev.option, got_ev.verb,
                     m_tdata[TDATA_W-1:18]);
            fail_count++;
          end
        end
      end
    end
    pending = expected_events.size();
  end

endmodule

// File: tb/tb_top.sv
// Testbench top for the telnet deframer: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import tsd_pkg::*;

  localparam int RANDOM_ITEMS = 950;
  localparam int QUIET_TAIL   = 100;

  logic               clk;
  logic               rst;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata;   // in_byte
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;   // event_byte, event_option, event_verb, zero pad
  logic [2:0]         m_axis_tuser;   // event_kind

  int   fail_count;
  int   pending;
  int   sent_count;
  logic quiet;

  telnet_stream_deframer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  tsd_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_axis_tvalid),
    .s_tready   (s_axis_tready),
    .s_tdata    (s_axis_tdata),
    .m_tvalid   (m_axis_tvalid),
    .m_tready   (m_axis_tready),
    .m_tdata    (m_axis_tdata),
    .m_tuser    (m_axis_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  // holds tvalid high across back-to-back items; gaps lower it for a burst
  task automatic send_byte(input logic [7:0] b);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    sent_count++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // escapes IAC so a body byte stays body data
  task automatic send_body_byte(input logic [7:0] b);
    if (b == CODE_IAC) send_byte(CODE_IAC);
    send_byte(b);
  endtask

  task automatic send_random_sequence();
    int         pick;
    int         body_len;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_byte(8'($urandom_range(0, 254)));
    end else if (pick < 45) begin
      do b = 8'($urandom_range(0, 255));
      while ((b >= CODE_WILL && b <= CODE_DONT) || b == CODE_SB);
      send_byte(CODE_IAC);
      send_byte(b);
    end else if (pick < 65) begin
      send_byte(CODE_IAC);
      send_byte(8'($urandom_range(CODE_WILL, CODE_DONT)));
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 90) begin
      send_byte(CODE_IAC);
      send_byte(CODE_SB);
      send_byte(8'($urandom_range(0, 255)));
      body_len = $urandom_range(0, 8);
      repeat (body_len) begin
        case ($urandom_range(0, 9))
          0: begin
            send_byte(CODE_IAC);
            send_byte(CODE_IAC);
          end
          1: begin
            // IAC then a stray byte inside the body
            do b = 8'($urandom_range(0, 254)); while (b == CODE_SE);
            send_byte(CODE_IAC);
            send_byte(b);
          end
          default: send_body_byte(8'($urandom_range(0, 255)));
        endcase
      end
      // most bodies are closed; some are left open and soak up what follows
      if ($urandom_range(0, 9) != 0) begin
        send_byte(CODE_IAC);
        send_byte(CODE_SE);
      end
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // receiver: ready with random stall bursts until the quiet tail
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    int         random_start;
    logic [7:0] directed[$];
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    m_axis_tready = 1'b0;
    sent_count    = 0;
    quiet         = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed = '{8'h00, 8'hFE,
                 CODE_IAC, CODE_IAC,
                 CODE_IAC, CODE_WILL, 8'h01,
                 CODE_IAC, CODE_WONT, 8'h80,
                 CODE_IAC, CODE_DO,   8'h7F,
                 CODE_IAC, CODE_DONT, 8'hFF,
                 CODE_IAC, CODE_SB,   8'hFF,
                 8'h00, CODE_SB,
                 CODE_IAC, CODE_IAC,
                 CODE_IAC, 8'h33,
                 CODE_IAC, CODE_SE};
    foreach (directed[i]) send_byte(directed[i]);
    hold_until_drained();

    random_start = sent_count;
    while (sent_count < random_start + RANDOM_ITEMS) begin
      if (sent_count >= random_start + RANDOM_ITEMS / 2 &&
          sent_count < random_start + RANDOM_ITEMS / 2 + 4)
        hold_until_drained();
      if (sent_count >= random_start + RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
      send_random_sequence();
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
